/* hw/rtl/vqtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqtd_pkg
// Types, codes and texel expansion for the 2x2 VQ texture decoder.
// ----------------------------------------------------------------------------
package vqtd_pkg;

  localparam int unsigned CodebookEntriesDefault = 256;
  localparam int unsigned MaxWidthLog2           = 10;

  localparam int unsigned CounterW = 18;
  localparam int unsigned QuadW    = 9;
  localparam int unsigned PosW     = 10;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 4;

  // Command codes
  typedef enum logic [1:0] {
    CmdStart  = 2'd0,
    CmdLoad   = 2'd1,
    CmdDecode = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgPixelFormat = 1'd0;
  localparam logic [CfgIndexW-1:0] CfgLevelWidth  = 1'd1;

  // Pixel format codes
  localparam logic [2:0] FmtArgb1555 = 3'd0;
  localparam logic [2:0] FmtRgb565   = 3'd1;
  localparam logic [2:0] FmtArgb4444 = 3'd2;
  localparam logic [2:0] FmtRgb555   = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  entry_address;
    logic [15:0] texel_word;
    logic [7:0]  code_index;
  } vqtd_in_t;

  typedef struct packed {
    logic [PosW-1:0] pixel_x;
    logic [PosW-1:0] pixel_y;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic            status;
    logic            last;
  } vqtd_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       status;
  } vqtd_color_t;

  // Bit-replicating expansion to RGBA8; unsupported formats give zeros and set status.
  function automatic vqtd_color_t expand_texel(logic [2:0] fmt, logic [15:0] c);
    vqtd_color_t col;
    col = '0;
    unique case (fmt)
      FmtArgb1555, FmtRgb555: begin
        col.red   = {c[14:10], c[14:12]};
        col.green = {c[9:5], c[9:7]};
        col.blue  = {c[4:0], c[4:2]};
        col.alpha = (fmt == FmtArgb1555) ? {8{c[15]}} : 8'hff;
      end
      FmtRgb565: begin
        col.red   = {c[15:11], c[15:13]};
        col.green = {c[10:5], c[10:9]};
        col.blue  = {c[4:0], c[4:2]};
        col.alpha = 8'hff;
      end
      FmtArgb4444: begin
        col.red   = {c[11:8], c[11:8]};
        col.green = {c[7:4], c[7:4]};
        col.blue  = {c[3:0], c[3:0]};
        col.alpha = {c[15:12], c[15:12]};
      end
      default: begin
        col.status = 1'b1;
      end
    endcase
    return col;
  endfunction

endpackage

/* hw/rtl/vqtd_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqtd_stream_if
// Valid/ready stream carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface vqtd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/vq_texture_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vq_texture_decode
// 2x2 vector-quantized texture decoder, twiddled index order, RGBA8 out.
// ----------------------------------------------------------------------------
// Usage: in_i takes one command word per handshake: start level (clears the
// quad counter), load one codebook texel, or decode one index byte. out_o
// returns four pixel words per decode, column-major within the 2x2 quad,
// last set on the fourth. Loads, starts and unknown commands return nothing.
// Configuration (pixel format, level width log2) is written through
// cfg_we_i / cfg_index_i / cfg_wdata_i while the block is idle.
// Pipeline: each texel passes the codebook read register, then the output
// register. A decode word holds the input register until its fourth texel is
// read, when the next word can be accepted; loads and starts retire unread.
// Throughput: one texel per cycle while out_o is not stalled (single read port).
// Reset: format RGB565, level width log2 3, quad counter zero. The codebook
// is not cleared; decode only entries that were loaded.
// Stall: a stalled output holds its word and freezes the whole pipeline;
// in_i.ready drops once the input register cannot retire.
// ----------------------------------------------------------------------------
module vq_texture_decode
  import vqtd_pkg::*;
#(
  parameter int unsigned CODEBOOK_ENTRIES = CodebookEntriesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  vqtd_stream_if.sink          in_i,
  vqtd_stream_if.source        out_o
);

  localparam int unsigned Depth  = CODEBOOK_ENTRIES * 4;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned EntryW = $clog2(CODEBOOK_ENTRIES);

  typedef logic [255:0][EntryW-1:0] entry_tab_t;

  // index byte -> entry, modulo the codebook size
  function automatic entry_tab_t build_entry_tab();
    entry_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = EntryW'(i % CODEBOOK_ENTRIES);
    end
    return tab;
  endfunction

  localparam entry_tab_t EntryTab = build_entry_tab();

  // Configuration
  logic [2:0] fmt_q;
  logic [3:0] lw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtRgb565;
      lw_q  <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPixelFormat: fmt_q <= cfg_wdata_i[2:0];
        CfgLevelWidth:  lw_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic     en;
  logic     s1_valid_q, s1_valid_d;
  vqtd_in_t s1_q;
  logic [1:0] k_q, k_d;
  logic     s1_decode, s1_load, s1_start, s1_done, rd_en, mem_we;
  logic     in_accept;

  assign en        = !out_o.valid || out_o.ready;
  assign s1_decode = s1_valid_q && (s1_q.command == CmdDecode);
  assign s1_load   = s1_valid_q && (s1_q.command == CmdLoad);
  assign s1_start  = s1_valid_q && (s1_q.command == CmdStart);
  assign rd_en     = en && s1_decode;
  assign s1_done   = en && s1_valid_q && (!s1_decode || (k_q == 2'd3));
  assign in_i.ready = !s1_valid_q || s1_done;
  assign in_accept = in_i.valid && in_i.ready;
  assign mem_we    = en && s1_load && ({1'b0, s1_q.entry_address} < 11'(Depth));

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end
    k_d = k_q;
    if (s1_done) begin
      k_d = 2'd0;
    end else if (rd_en) begin
      k_d = k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      k_q        <= 2'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      k_q        <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_i.data;
    end
  end

  // Quad counter
  logic [CounterW-1:0] quad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q <= '0;
    end else if (en && s1_start) begin
      quad_q <= '0;
    end else if (rd_en && (k_q == 2'd3)) begin
      quad_q <= quad_q + CounterW'(1);
    end
  end

  // Quad position: de-interleave counter, mask to the level
  logic [3:0]       lw_eff, qbits;
  logic [QuadW-1:0] qmask, qx, qy;
  logic [PosW-1:0]  px, py;

  always_comb begin
    if (lw_q == 4'd0) begin
      lw_eff = 4'd1;
    end else if (lw_q > 4'(MaxWidthLog2)) begin
      lw_eff = 4'(MaxWidthLog2);
    end else begin
      lw_eff = lw_q;
    end
    qbits = (lw_eff > 4'd10) ? 4'd9 : lw_eff - 4'd1;
    qmask = QuadW'((10'd1 << qbits) - 10'd1);
    for (int b = 0; b < QuadW; b++) begin
      qy[b] = quad_q[2*b];
      qx[b] = quad_q[2*b+1];
    end
    px = {qx & qmask, k_q[1]};
    py = {qy & qmask, k_q[0]};
  end

  // Codebook memory, one texel read per cycle while the output is not stalled
  logic [15:0]      mem [Depth];
  logic [15:0]      rd_data_q;
  logic [AddrW-1:0] rd_addr;

  assign rd_addr = {EntryTab[s1_q.code_index], k_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s1_q.entry_address[AddrW-1:0]] <= s1_q.texel_word;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Read stage side band
  logic            s2_valid_q;
  logic [PosW-1:0] s2_px_q, s2_py_q;
  logic            s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_decode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s2_px_q   <= px;
      s2_py_q   <= py;
      s2_last_q <= (k_q == 2'd3);
    end
  end

  // Output register
  logic        out_valid_q;
  vqtd_out_t   out_q, out_d;
  vqtd_color_t col;

  always_comb begin
    col           = expand_texel(fmt_q, rd_data_q);
    out_d.pixel_x = s2_px_q;
    out_d.pixel_y = s2_py_q;
    out_d.red     = col.red;
    out_d.green   = col.green;
    out_d.blue    = col.blue;
    out_d.alpha   = col.alpha;
    out_d.status  = col.status;
    out_d.last    = s2_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Checks
  a_quad_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en && s1_start) && !(rd_en && (k_q == 2'd3)) |=> $stable(quad_q))
    else $error("quad counter moved outside start or quad end");

  a_k_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != 2'd0) |-> s1_decode)
    else $error("texel index nonzero without a decode in flight");

  a_ready_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && in_i.ready |-> en)
    else $error("input taken while the input register is stalled");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last |-> out_q.pixel_x[0] && out_q.pixel_y[0])
    else $error("last word is not the bottom-right pixel");

endmodule

/* bench/vqtd_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqtd_pixel_checker
// Watches the command and pixel channels of the VQ texture decoder, keeps a
// shadow codebook, quad counter and register set, predicts the four pixels of
// every accepted decode word and compares each pixel word as it is accepted.
// ----------------------------------------------------------------------------
module vqtd_pixel_checker
  import vqtd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 word_valid_i,
  input  logic                 word_ready_i,
  input  vqtd_in_t             word_i,
  input  logic                 pixel_valid_i,
  input  logic                 pixel_ready_i,
  input  vqtd_out_t            pixel_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o,
  output int unsigned          pixels_o
);

  logic [2:0]          fmt_q;
  logic [3:0]          lw_q;
  logic [CounterW-1:0] quad_q;
  logic [15:0]         texel_mem [1024];
  vqtd_out_t           pixel_expect_q [$];
  int unsigned         mismatches;
  int unsigned         pixels_seen;

  function automatic vqtd_color_t rgba_of(input logic [2:0] fmt, input logic [15:0] t);
    vqtd_color_t c;
    c = '0;
    case (fmt)
      FmtArgb1555, FmtRgb555: begin
        c.red   = 8'(((t & 16'h7c00) >> 7) | ((t & 16'h7000) >> 12));
        c.green = 8'(((t & 16'h03e0) >> 2) | ((t & 16'h0380) >> 7));
        c.blue  = 8'(((t & 16'h001f) << 3) | ((t & 16'h001c) >> 2));
        c.alpha = (fmt == FmtRgb555 || t[15]) ? 8'hff : 8'h00;
      end
      FmtRgb565: begin
        c.red   = 8'(((t & 16'hf800) >> 8) | ((t & 16'he000) >> 13));
        c.green = 8'(((t & 16'h07e0) >> 3) | ((t & 16'h0600) >> 9));
        c.blue  = 8'(((t & 16'h001f) << 3) | ((t & 16'h001c) >> 2));
        c.alpha = 8'hff;
      end
      FmtArgb4444: begin
        c.red   = 8'(((t & 16'h0f00) >> 4) | ((t & 16'h0f00) >> 8));
        c.green = 8'((t & 16'h00f0) | ((t & 16'h00f0) >> 4));
        c.blue  = 8'(((t & 16'h000f) << 4) | (t & 16'h000f));
        c.alpha = 8'(((t & 16'hf000) >> 8) | ((t & 16'hf000) >> 12));
      end
      default: begin
        c.status = 1'b1;
      end
    endcase
    return c;
  endfunction

  // Queue the four pixels of the next quad and step the counter.
  task automatic push_quad(input logic [7:0] code);
    int unsigned      lw;
    int unsigned      qbits;
    logic [QuadW-1:0] qx;
    logic [QuadW-1:0] qy;
    logic [QuadW-1:0] qmask;
    vqtd_color_t      col;
    vqtd_out_t        px;
    lw = 32'(lw_q);
    if (lw < 1) lw = 1;
    if (lw > MaxWidthLog2) lw = MaxWidthLog2;
    qbits = lw - 1;
    qmask = QuadW'((1 << qbits) - 1);
    // twiddled order: even counter bits are y, odd bits are x
    for (int b = 0; b < QuadW; b++) begin
      qy[b] = quad_q[2*b];
      qx[b] = quad_q[2*b+1];
    end
    qx &= qmask;
    qy &= qmask;
    for (int k = 0; k < 4; k++) begin
      col = rgba_of(fmt_q, texel_mem[{code, 2'(k)}]);
      px.pixel_x = {qx, 1'b0} + PosW'(k >> 1);
      px.pixel_y = {qy, 1'b0} + PosW'(k & 1);
      px.red     = col.red;
      px.green   = col.green;
      px.blue    = col.blue;
      px.alpha   = col.alpha;
      px.status  = col.status;
      px.last    = (k == 3);
      pixel_expect_q.push_back(px);
    end
    quad_q = quad_q + CounterW'(1);
  endtask

  task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vqtd_out_t want;
    if (!rst_ni) begin
      fmt_q       = FmtRgb565;
      lw_q        = 4'd3;
      quad_q      = '0;
      mismatches  = 0;
      pixels_seen = 0;
      pixel_expect_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
      pixels_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgPixelFormat: fmt_q = cfg_wdata_i[2:0];
          CfgLevelWidth:  lw_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (word_valid_i && word_ready_i) begin
        case (word_i.command)
          CmdStart:  quad_q = '0;
          CmdLoad:   texel_mem[word_i.entry_address] = word_i.texel_word;
          CmdDecode: push_quad(word_i.code_index);
          default: ;
        endcase
      end
      if (pixel_valid_i && pixel_ready_i) begin
        pixels_seen++;
        if (pixel_expect_q.size() == 0) begin
          $error("pixel word with nothing expected: x=%0d y=%0d", pixel_i.pixel_x,
                 pixel_i.pixel_y);
          mismatches++;
        end else begin
          want = pixel_expect_q.pop_front();
          check_field("pixel_x", want.pixel_x, pixel_i.pixel_x);
          check_field("pixel_y", want.pixel_y, pixel_i.pixel_y);
          check_field("red",     10'(want.red),    10'(pixel_i.red));
          check_field("green",   10'(want.green),  10'(pixel_i.green));
          check_field("blue",    10'(want.blue),   10'(pixel_i.blue));
          check_field("alpha",   10'(want.alpha),  10'(pixel_i.alpha));
          check_field("status",  10'(want.status), 10'(pixel_i.status));
          check_field("last",    10'(want.last),   10'(pixel_i.last));
        end
      end
      pending_o <= pixel_expect_q.size();
      errors_o  <= mismatches;
      pixels_o  <= pixels_seen;
    end
  end

endmodule

/* bench/tb_vq_texture_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vq_texture_decode
// Drives codebook loads, level starts and index decodes into the decoder
// under every pixel format and a spread of level widths, with random gaps
// on both channels; the checker predicts and compares every pixel word.
// ----------------------------------------------------------------------------
module tb_vq_texture_decode;
  import vqtd_pkg::*;

  localparam logic [1:0]  CmdUnused      = 2'd3;
  localparam logic [2:0]  FmtUnsupported3 = 3'd3;
  localparam logic [2:0]  FmtUnsupported4 = 3'd4;
  localparam logic [2:0]  FmtUnsupported6 = 3'd6;
  localparam logic [2:0]  FmtUnsupported7 = 3'd7;
  localparam int unsigned NumPhases      = 10;
  localparam int unsigned PhaseWords     = 13;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned CalmPhase      = 5;

  localparam logic [2:0] PhaseFmt [NumPhases] = '{
    FmtArgb1555, FmtArgb4444, FmtRgb555, FmtUnsupported3, FmtUnsupported7,
    FmtRgb565, FmtUnsupported6, FmtArgb4444, FmtUnsupported4, FmtArgb1555};
  localparam logic [3:0] PhaseLw [NumPhases] = '{
    4'd1, 4'd0, 4'd10, 4'd4, 4'd15, 4'd2, 4'd11, 4'd6, 4'd3, 4'd9};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_wdata;
  logic                 calm;
  logic                 slot_loaded [1024];
  int unsigned          words_sent;
  int unsigned          decodes_sent;
  int unsigned          pending;
  int unsigned          errors;
  int unsigned          pixels;

  vqtd_stream_if #(.payload_t(vqtd_in_t))  word_if ();
  vqtd_stream_if #(.payload_t(vqtd_out_t)) pixel_if ();

  vq_texture_decode i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (word_if),
    .out_o      (pixel_if)
  );

  vqtd_pixel_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .word_valid_i (word_if.valid),
    .word_ready_i (word_if.ready),
    .word_i       (word_if.data),
    .pixel_valid_i(pixel_if.valid),
    .pixel_ready_i(pixel_if.ready),
    .pixel_i      (pixel_if.data),
    .pending_o    (pending),
    .errors_o     (errors),
    .pixels_o     (pixels)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // sink side: stalls at random with probability 17 percent, never during the calm phase
  initial begin
    pixel_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pixel_if.ready <= calm || ($urandom_range(0, 99) >= 17);
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [9:0] addr,
                           input logic [15:0] texel, input logic [7:0] code);
    vqtd_in_t w;
    w.command       = cmd;
    w.entry_address = addr;
    w.texel_word    = texel;
    w.code_index    = code;
    while (!calm && $urandom_range(0, 99) < 17) begin
      word_if.valid <= 1'b0;
      @(posedge clk);
    end
    word_if.valid <= 1'b1;
    word_if.data  <= w;
    do @(posedge clk); while (!word_if.ready);
    if (cmd != CmdUnused) words_sent++;
    if (cmd == CmdDecode) decodes_sent++;
    if (cmd == CmdLoad) slot_loaded[addr] = 1'b1;
  endtask

  // Wait out every pending pixel plus the pipeline depth so a load or start
  // in flight has settled before the registers change.
  task automatic settle_idle();
    int unsigned guard;
    guard = 0;
    word_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_mode(input logic [2:0] fmt, input logic [3:0] lw);
    cfg_we    <= 1'b1;
    cfg_index <= CfgPixelFormat;
    cfg_wdata <= {1'($urandom_range(0, 1)), fmt};
    @(posedge clk);
    cfg_index <= CfgLevelWidth;
    cfg_wdata <= lw;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned phase_words;
    int unsigned pick;
    int unsigned tries;
    logic [7:0]  code;
    logic [7:0]  entry;
    word_if.valid <= 1'b0;
    word_if.data  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CfgPixelFormat;
    cfg_wdata     <= '0;
    calm          = 1'b0;
    words_sent    = 0;
    decodes_sent  = 0;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme texels in entries 0 and 255, reset register values
    send_word(CmdLoad, 10'd0, 16'h0000, 8'hff);
    send_word(CmdLoad, 10'd1, 16'hffff, 8'h00);
    send_word(CmdLoad, 10'd2, 16'h8000, 8'h00);
    send_word(CmdLoad, 10'd3, 16'h7fff, 8'h00);
    send_word(CmdLoad, 10'd1020, 16'hffff, 8'h00);
    send_word(CmdLoad, 10'd1021, 16'h0000, 8'h00);
    send_word(CmdLoad, 10'd1022, 16'haaaa, 8'h00);
    send_word(CmdLoad, 10'd1023, 16'h5555, 8'h00);
    send_word(CmdUnused, 10'h3ff, 16'hffff, 8'hff);
    send_word(CmdDecode, 10'h3ff, 16'hffff, 8'd0);
    send_word(CmdDecode, 10'h000, 16'h0000, 8'd255);
    send_word(CmdDecode, 10'h155, 16'h1234, 8'd0);
    send_word(CmdDecode, 10'h2aa, 16'hedcb, 8'd255);
    send_word(CmdDecode, 10'h000, 16'h0000, 8'd255);
    send_word(CmdStart, 10'h3ff, 16'hffff, 8'hff);
    send_word(CmdDecode, 10'h000, 16'h0000, 8'd0);
    send_word(CmdLoad, 10'd1023, 16'h1234, 8'h00);
    send_word(CmdDecode, 10'h000, 16'h0000, 8'd255);
    send_word(CmdUnused, 10'h000, 16'h0000, 8'h00);
    send_word(CmdDecode, 10'h3ff, 16'hffff, 8'd0);

    for (int p = 0; p < NumPhases; p++) begin
      settle_idle();
      set_mode(PhaseFmt[p], PhaseLw[p]);
      calm = (p == CalmPhase);
      phase_words = 0;
      while (phase_words < PhaseWords) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // decode only entries whose four slots all hold a texel
          code  = 8'($urandom_range(0, 255));
          tries = 0;
          while (!(slot_loaded[{code, 2'd0}] && slot_loaded[{code, 2'd1}] &&
                   slot_loaded[{code, 2'd2}] && slot_loaded[{code, 2'd3}]) && tries < 16) begin
            code = 8'($urandom_range(0, 255));
            tries++;
          end
          if (tries == 16) code = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          send_word(CmdDecode, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                    code);
          phase_words++;
        end else if (pick < 75) begin
          entry = 8'($urandom_range(0, 255));
          for (int k = 0; k < 4; k++) begin
            send_word(CmdLoad, {entry, 2'(k)}, 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)));
          end
          phase_words += 4;
        end else if (pick < 85) begin
          send_word(CmdLoad, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(0, 255)));
          phase_words++;
        end else if (pick < 93) begin
          send_word(CmdStart, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(0, 255)));
          phase_words++;
        end else begin
          send_word(CmdUnused, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(0, 255)));
        end
      end
      calm = 1'b0;
    end

    settle_idle();
    if (pending != 0) $error("%0d expected pixel words never arrived", pending);
    $display("Run covered %0d command words, %0d decodes and %0d pixel words checked,",
             words_sent, decodes_sent, pixels);
    $display("over %0d register settings spanning all formats and widths 0 to 15.",
             NumPhases + 1);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
